>>> hw/rtl/rte_pkg.sv
`default_nettype none

package rte_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {
    FUNC_REGISTER   = 2'd0,
    FUNC_DEREGISTER = 2'd1,
    FUNC_PURGE      = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_EXISTS   = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_ZEROKEY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_MOVE,
    ST_APPEND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] reg_key;
    logic [31:0] reg_index;
    logic [63:0] region_address;
    logic [63:0] region_size;
    logic [31:0] owner_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entries_used;
    logic [3:0] slot_touched;
    logic [4:0] removed_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] index;
    logic [63:0] address;
    logic [63:0] size;
    logic [31:0] owner;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/rte_table.sv
`default_nettype none

module rte_table (
  input  wire logic                     clk_i,
  input  wire rte_pkg::tbl_wr_t         wr_i,
  input  wire logic [rte_pkg::IDX_W-1:0] rd_addr_i,
  output rte_pkg::entry_t               rd_data_o
);
  import rte_pkg::*;

  entry_t mem_q [TABLE_SLOTS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read data is registered: it lands in the cycle after the address
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/registration_table_engine.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  in_req_i  (rte_pkg::req_t)
// response  out        out_valid_o / out_stall_i out_rsp_o (rte_pkg::rsp_t)
//
// One request at a time; the scan of the used entries is paced by the single read port
// of the entry table (one entry read per cycle while scanning).
// Reset clears the control state and the entry count, not the table contents;
// slots at or above the count are never compared or moved. The response sits in its own
// register, so a stalled response does not block the next request from being taken.

module registration_table_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire rte_pkg::req_t   in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rte_pkg::rsp_t        out_rsp_o
);
  import rte_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [IDX_W-1:0] cmp_q, cmp_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] hole_q, hole_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  status_e          status_q, status_d;
  rsp_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic             accept;
  logic             in_zero_key;
  logic             table_full;
  logic             hit;
  logic             scan_done;
  logic             out_free;
  logic [CNT_W-1:0] last_cnt;
  logic [31:0]      used_w;
  logic [31:0]      hole_w;
  logic [31:0]      removed_w;

  rte_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_zero_key = (in_req_i.reg_key == 32'd0);
  assign table_full  = (used_q >= CNT_W'(TABLE_SLOTS));
  assign last_cnt    = used_q - CNT_W'(1);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    hit = 1'b0;
    if (pend_q) begin
      if (req_q.func == FUNC_PURGE) begin
        hit = (rd_data.owner == req_q.owner_id);
      end else begin
        hit = (rd_data.key == req_q.reg_key) && (rd_data.index == req_q.reg_index);
      end
    end
  end

  assign scan_done = !pend_q && (issue_q >= used_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_i.func)
            FUNC_REGISTER:   state_d = (in_zero_key || table_full) ? ST_DONE : ST_SCAN;
            FUNC_DEREGISTER: state_d = in_zero_key ? ST_DONE : ST_SCAN;
            FUNC_PURGE:      state_d = ST_SCAN;
            default:         state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = (req_q.func == FUNC_REGISTER) ? ST_DONE : ST_FETCH;
        end else if (scan_done) begin
          state_d = (req_q.func == FUNC_REGISTER) ? ST_APPEND : ST_DONE;
        end
      end
      ST_FETCH:  state_d = ST_MOVE;
      ST_MOVE:   state_d = (req_q.func == FUNC_PURGE) ? ST_SCAN : ST_DONE;
      ST_APPEND: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign used_w    = 32'(used_q);
  assign hole_w    = 32'(hole_q);
  assign removed_w = 32'(removed_q);

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    used_d      = used_q;
    issue_d     = issue_q;
    cmp_d       = cmp_q;
    pend_d      = pend_q;
    hole_d      = hole_q;
    removed_d   = removed_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = issue_q[IDX_W-1:0];
    tbl_wr      = '{en: 1'b0, addr: hole_q, data: rd_data};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d     = in_req_i;
          issue_d   = '0;
          pend_d    = 1'b0;
          hole_d    = '0;
          removed_d = '0;
          status_d  = STATUS_OK;
          case (in_req_i.func)
            FUNC_REGISTER: begin
              if (in_zero_key) begin
                status_d = STATUS_ZEROKEY;
              end else if (table_full) begin
                status_d = STATUS_FULL;
              end
            end
            FUNC_DEREGISTER: begin
              if (in_zero_key) begin
                status_d = STATUS_ZEROKEY;
              end
            end
            default: status_d = STATUS_OK;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // drop the read in flight; the hit slot is the hole (a register hit leaves it zero)
          pend_d = 1'b0;
          hole_d = cmp_q;
          if (req_q.func == FUNC_REGISTER) begin
            status_d = STATUS_EXISTS;
            hole_d   = '0;
          end
        end else if (issue_q < used_q) begin
          pend_d  = 1'b1;
          cmp_d   = issue_q[IDX_W-1:0];
          issue_d = issue_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (scan_done && (req_q.func == FUNC_DEREGISTER)) begin
            status_d = STATUS_NOTFOUND;
          end
        end
      end
      ST_FETCH: begin
        rd_addr = last_cnt[IDX_W-1:0];
      end
      ST_MOVE: begin
        // fill the hole with the last entry
        tbl_wr    = '{en: 1'b1, addr: hole_q, data: rd_data};
        used_d    = last_cnt;
        removed_d = removed_q + CNT_W'(1);
        issue_d   = CNT_W'(hole_q);
        pend_d    = 1'b0;
      end
      ST_APPEND: begin
        tbl_wr = '{en: 1'b1, addr: used_q[IDX_W-1:0],
                   data: '{key: req_q.reg_key, index: req_q.reg_index,
                           address: req_q.region_address, size: req_q.region_size,
                           owner: req_q.owner_id}};
        used_d = used_q + CNT_W'(1);
        hole_d = used_q[IDX_W-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.entries_used  = used_w[4:0];
          out_d.slot_touched  = (req_q.func == FUNC_PURGE) ? 4'd0 : hole_w[3:0];
          out_d.removed_count = removed_w[4:0];
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_q     <= cmp_d;
    hole_q    <= hole_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rte_pkg::*;

  // Opcode that the block has no operation for
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  registration_table_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the registration table
  logic [31:0] tbl_key   [TABLE_SLOTS];
  logic [31:0] tbl_index [TABLE_SLOTS];
  logic [63:0] tbl_addr  [TABLE_SLOTS];
  logic [63:0] tbl_size  [TABLE_SLOTS];
  logic [31:0] tbl_owner [TABLE_SLOTS];
  int unsigned tbl_used = 0;

  rsp_t        pending_rsp[$];
  int unsigned error_count = 0;
  bit          calm = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int find_pair(logic [31:0] key, logic [31:0] idx);
    for (int s = 0; s < tbl_used; s++) begin
      if (tbl_key[s] == key && tbl_index[s] == idx) return s;
    end
    return -1;
  endfunction

  // Fill the hole with the last entry and shrink the table
  function automatic void remove_slot(int s);
    int last;
    last = tbl_used - 1;
    tbl_key[s]   = tbl_key[last];
    tbl_index[s] = tbl_index[last];
    tbl_addr[s]  = tbl_addr[last];
    tbl_size[s]  = tbl_size[last];
    tbl_owner[s] = tbl_owner[last];
    tbl_used     = last;
  endfunction

  function automatic rsp_t predict_request(req_t rq);
    rsp_t r;
    int   s;
    int   removed;
    r = '0;
    removed = 0;
    case (rq.func)
      FUNC_REGISTER: begin
        if (rq.reg_key == '0) begin
          r.status = STATUS_ZEROKEY;
        end else if (tbl_used >= TABLE_SLOTS) begin
          r.status = STATUS_FULL;
        end else if (find_pair(rq.reg_key, rq.reg_index) >= 0) begin
          r.status = STATUS_EXISTS;
        end else begin
          s = tbl_used;
          tbl_key[s]   = rq.reg_key;
          tbl_index[s] = rq.reg_index;
          tbl_addr[s]  = rq.region_address;
          tbl_size[s]  = rq.region_size;
          tbl_owner[s] = rq.owner_id;
          tbl_used     = s + 1;
          r.slot_touched = 4'(s);
        end
      end
      FUNC_DEREGISTER: begin
        if (rq.reg_key == '0) begin
          r.status = STATUS_ZEROKEY;
        end else begin
          s = find_pair(rq.reg_key, rq.reg_index);
          if (s >= 0) begin
            remove_slot(s);
            r.slot_touched = 4'(s);
            removed = 1;
          end else begin
            r.status = STATUS_NOTFOUND;
          end
        end
      end
      FUNC_PURGE: begin
        s = 0;
        while (s < tbl_used) begin
          if (tbl_owner[s] == rq.owner_id) begin
            remove_slot(s);
            removed++;
          end else begin
            s++;
          end
        end
      end
      default: begin
      end
    endcase
    r.entries_used  = 5'(tbl_used);
    r.removed_count = 5'(removed);
    return r;
  endfunction

  // Check responses in order, then record the expectation of a new request
  always @(posedge clk_i) begin
    rsp_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: %p", out_rsp_o);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp_o.status);
          error_count++;
        end
        if (out_rsp_o.entries_used !== want.entries_used) begin
          $error("entries_used: expected %0d, actual %0d",
                 want.entries_used, out_rsp_o.entries_used);
          error_count++;
        end
        if (out_rsp_o.slot_touched !== want.slot_touched) begin
          $error("slot_touched: expected %0d, actual %0d",
                 want.slot_touched, out_rsp_o.slot_touched);
          error_count++;
        end
        if (out_rsp_o.removed_count !== want.removed_count) begin
          $error("removed_count: expected %0d, actual %0d",
                 want.removed_count, out_rsp_o.removed_count);
          error_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_rsp.push_back(predict_request(in_req_i));
    end
  end

  // Response back-pressure in bursts, none once calm
  initial begin : out_stall_driver
    int n;
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(2) == 0) begin
        n = $urandom_range(13, 1);
        out_stall_i <= 1'b1;
      end else begin
        n = $urandom_range(24, 1);
        out_stall_i <= 1'b0;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // Called at a clock edge; returns at the edge that takes the request
  task automatic send_request(req_t rq);
    int gap;
    gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(13, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic req_t make_req(logic [1:0] func, logic [31:0] key, logic [31:0] idx,
                                    logic [63:0] addr, logic [63:0] size,
                                    logic [31:0] owner);
    req_t rq;
    rq.func           = func;
    rq.reg_key        = key;
    rq.reg_index      = idx;
    rq.region_address = addr;
    rq.region_size    = size;
    rq.owner_id       = owner;
    return rq;
  endfunction

  // Small key, index and owner pools so that hits, duplicates and purges happen
  function automatic req_t random_request(int reg_pct);
    req_t rq;
    int   roll;
    int   pick;
    rq = '0;
    roll = $urandom_range(99);
    rq.reg_key = (roll < 5) ? 32'd0 : (roll < 70) ? 32'($urandom_range(6, 1)) : $urandom;
    rq.reg_index = ($urandom_range(3) != 0) ? 32'($urandom_range(3)) : $urandom;
    rq.region_address = {$urandom, $urandom};
    rq.region_size    = {$urandom, $urandom};
    rq.owner_id = ($urandom_range(4) != 0) ? 32'($urandom_range(3)) : $urandom;
    roll = $urandom_range(99);
    if (roll < reg_pct) begin
      rq.func = FUNC_REGISTER;
    end else if (roll < reg_pct + (100 - reg_pct) * 6 / 10) begin
      rq.func = FUNC_DEREGISTER;
      if (tbl_used != 0 && $urandom_range(2) != 0) begin
        pick = $urandom_range(tbl_used - 1);
        rq.reg_key   = tbl_key[pick];
        rq.reg_index = tbl_index[pick];
      end
    end else if (roll < 95) begin
      rq.func = FUNC_PURGE;
    end else begin
      rq.func = FUNC_UNUSED;
    end
    return rq;
  endfunction

  task automatic test_register_checks();
    send_request(make_req(FUNC_REGISTER, '0, 32'h1, 64'h1, 64'h1, 32'h1));
    send_request(make_req(FUNC_REGISTER, '1, '0, '0, '1, '0));
    send_request(make_req(FUNC_REGISTER, '1, '0, 64'h5, 64'h5, 32'h5));
    send_request(make_req(FUNC_REGISTER, 32'h1, '1, '1, '0, '1));
    send_request(make_req(FUNC_DEREGISTER, '0, '1, '0, '0, '0));
    send_request(make_req(FUNC_DEREGISTER, 32'h1, '0, '0, '0, '0));
  endtask

  task automatic test_fill_table();
    for (int i = 2; i < TABLE_SLOTS; i++) begin
      send_request(make_req(FUNC_REGISTER, 32'h100 + 32'(i), 32'(i),
                            {$urandom, $urandom}, {$urandom, $urandom}, 32'(i % 3)));
    end
    send_request(make_req(FUNC_REGISTER, 32'h200, '0, '0, '0, '0));
    // zero key wins over a full table
    send_request(make_req(FUNC_REGISTER, '0, '0, '0, '0, '0));
  endtask

  task automatic test_deregister();
    send_request(make_req(FUNC_DEREGISTER, '1, '0, '0, '0, '0));
    send_request(make_req(FUNC_DEREGISTER, 32'h10e, 32'd14, '0, '0, '0));
    send_request(make_req(FUNC_DEREGISTER, 32'h105, 32'd5, '0, '0, '0));
  endtask

  task automatic test_purge();
    send_request(make_req(FUNC_PURGE, '0, '0, '0, '0, 32'h1));
    send_request(make_req(FUNC_PURGE, '0, '0, '0, '0, 32'hdead_beef));
    send_request(make_req(FUNC_PURGE, '0, '0, '0, '0, 32'h0));
    send_request(make_req(FUNC_UNUSED, '1, '1, '1, '1, '1));
  endtask

  task automatic test_random();
    for (int n = 0; n < 480; n++) begin
      if (n >= 420) calm = 1'b1;
      // alternate filling and draining phases so the table reaches full
      send_request(random_request(((n / 40) % 2 == 1) ? 75 : 45));
    end
  endtask

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      tbl_key[s]   = '0;
      tbl_index[s] = '0;
      tbl_addr[s]  = '0;
      tbl_size[s]  = '0;
      tbl_owner[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_register_checks();
    test_fill_table();
    test_deregister();
    test_purge();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
